### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define SCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// shared constants and types of the shortest common supersequence core
// ----------------------------------------------------------------------------
package scs_pkg;

  // default and largest string length
  localparam int MaxLenDef = 32;

  // row index and table value widths, sized for the largest string length
  localparam int RowW = 5;
  localparam int ValW = 6;

  // command codes of the func field
  localparam logic [1:0] FuncAppendFirst  = 2'd0;
  localparam logic [1:0] FuncAppendSecond = 2'd1;
  localparam logic [1:0] FuncRun          = 2'd2;

  // wavefront link between neighboring cells
  typedef struct packed {
    logic            valid;
    logic [7:0]      ch;
    logic [RowW-1:0] row;
    logic [ValW-1:0] cur;
    logic [ValW-1:0] prev;
  } scs_link_t;

endpackage

### rtl/core/scs_cell.sv
// ----------------------------------------------------------------------------
// scs_cell
// one column of the lcs table: holds a second-string byte, computes one
// cell per beat of the wavefront and keeps its column in a small memory
// ----------------------------------------------------------------------------
module scs_cell #(
  parameter int MAX_LEN = scs_pkg::MaxLenDef,
  parameter int IW      = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clr_i,
  input  logic                       ld_en_i,
  input  logic [7:0]                 ld_ch_i,
  output logic [7:0]                 ch_o,
  input  scs_pkg::scs_link_t         link_i,
  output scs_pkg::scs_link_t         link_o,
  input  logic [IW-1:0]              rd_addr_a_i,
  input  logic [IW-1:0]              rd_addr_b_i,
  output logic [scs_pkg::ValW-1:0]   rd_a_o,
  output logic [scs_pkg::ValW-1:0]   rd_b_o
);

  logic [7:0]               col_ch_q;
  logic                     valid_q;
  logic [7:0]               ch_q;
  logic [scs_pkg::RowW-1:0] row_q;
  logic [scs_pkg::ValW-1:0] cur_q;
  logic [scs_pkg::ValW-1:0] prev_q;
  logic [scs_pkg::ValW-1:0] res;
  logic [scs_pkg::ValW-1:0] col_mem [MAX_LEN];

  // lcs recurrence: left and diagonal from the neighbor, up from this cell
  always_comb begin
    if (link_i.ch == col_ch_q) begin
      res = link_i.prev + scs_pkg::ValW'(1);
    end else if (cur_q > link_i.cur) begin
      res = cur_q;
    end else begin
      res = link_i.cur;
    end
  end

  // column byte
  always_ff @(posedge clk_i) begin
    if (ld_en_i) begin
      col_ch_q <= ld_ch_i;
    end
  end

  // wavefront registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cur_q   <= '0;
      prev_q  <= '0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
      cur_q   <= '0;
      prev_q  <= '0;
    end else begin
      valid_q <= link_i.valid;
      if (link_i.valid) begin
        cur_q  <= res;
        prev_q <= cur_q;
      end
    end
  end

  // payload passed along with the beat
  always_ff @(posedge clk_i) begin
    if (link_i.valid) begin
      ch_q  <= link_i.ch;
      row_q <= link_i.row;
    end
  end

  // column memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (link_i.valid && !clr_i) begin
      col_mem[link_i.row[IW-1:0]] <= res;
    end
    rd_a_o <= col_mem[rd_addr_a_i];
    rd_b_o <= col_mem[rd_addr_b_i];
  end

  assign ch_o         = col_ch_q;
  assign link_o.valid = valid_q;
  assign link_o.ch    = ch_q;
  assign link_o.row   = row_q;
  assign link_o.cur   = cur_q;
  assign link_o.prev  = prev_q;

endmodule

### rtl/core/shortest_common_supersequence_core.sv
// ----------------------------------------------------------------------------
// shortest_common_supersequence_core
// builds the shortest common supersequence of two byte strings via the lcs
// table, filled by a row of column cells as a diagonal wavefront
// ----------------------------------------------------------------------------
// channel  dir  tdata                           tlast  tuser
// s_axis   in   [1:0] func, [9:2] symbol        -      -
// m_axis   out  [7:0] out_symbol                last   truncated
//
// an append is taken while idle; a run fills the table (first string bytes
// enter the cell row one per cycle), then traces back through ST_TB, with
// ST_CMP added on a mismatch (column memory reads are registered), then
// emits each byte through ST_RD, ST_LD and ST_WAIT plus any output stall.
// reset clears counts, flags and control; no clearing pass is needed.
// s_axis_tready is high only while idle; one command is worked at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shortest_common_supersequence_core #(
  parameter int MAX_LEN = scs_pkg::MaxLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] func, [9:2] symbol, rest zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_symbol
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // [0] truncated
);

  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int LW = $clog2(2 * MAX_LEN + 1);
  localparam int RW = (MAX_LEN > 1) ? $clog2(2 * MAX_LEN) : 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FILL, ST_TB, ST_CMP, ST_RD, ST_LD, ST_WAIT
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       f_cnt_q, s_cnt_q;
  logic                ovf_q, trunc_q;
  logic [LW-1:0]       fc_q;
  logic [CW-1:0]       r_q, c_q;
  logic [LW-1:0]       len_q, ptr_q;
  logic                m_valid_q, m_last_q, m_trunc_q;
  logic [7:0]          m_sym_q;
  logic [7:0]          f_chars [MAX_LEN];
  logic [7:0]          rb_mem [2*MAX_LEN];
  logic [7:0]          rb_rd_q;

  logic                accept;
  logic [1:0]          func;
  logic [7:0]          sym;
  logic                push;
  logic [7:0]          push_data;
  logic [CW-1:0]       ra_full, rb_full, c1_full, c2_full;
  logic [IW-1:0]       col_up, col_left;
  logic [7:0]          fch, sch;
  logic [scs_pkg::ValW-1:0] up_v, left_v;
  logic                cell_clr;

  scs_pkg::scs_link_t  links [MAX_LEN+1];
  logic [7:0]          col_ch [MAX_LEN];
  logic [scs_pkg::ValW-1:0] rd_a [MAX_LEN];
  logic [scs_pkg::ValW-1:0] rd_b [MAX_LEN];

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign func          = s_axis_tdata[1:0];
  assign sym           = s_axis_tdata[9:2];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cell_clr      = accept && (func == scs_pkg::FuncRun);

  // wavefront feed: first string bytes, one row per cycle
  assign links[0].valid = (state_q == ST_FILL) && (fc_q < LW'(f_cnt_q));
  assign links[0].ch    = f_chars[fc_q[IW-1:0]];
  assign links[0].row   = scs_pkg::RowW'(fc_q);
  assign links[0].cur   = '0;
  assign links[0].prev  = '0;

  // trace-back addresses: up is column c at row r-1, left is column c-1 at row r
  assign ra_full  = r_q - CW'(2);
  assign rb_full  = r_q - CW'(1);
  assign c1_full  = c_q - CW'(1);
  assign c2_full  = c_q - CW'(2);
  assign col_up   = c1_full[IW-1:0];
  assign col_left = c2_full[IW-1:0];

  // row of column cells
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    scs_cell #(
      .MAX_LEN(MAX_LEN),
      .IW     (IW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (cell_clr),
      .ld_en_i    (accept && (func == scs_pkg::FuncAppendSecond) &&
                   (s_cnt_q == CW'(j))),
      .ld_ch_i    (sym),
      .ch_o       (col_ch[j]),
      .link_i     (links[j]),
      .link_o     (links[j+1]),
      .rd_addr_a_i(ra_full[IW-1:0]),
      .rd_addr_b_i(rb_full[IW-1:0]),
      .rd_a_o     (rd_a[j]),
      .rd_b_o     (rd_b[j])
    );
  end

  // current pair of string bytes and neighbor table values
  assign fch    = f_chars[rb_full[IW-1:0]];
  assign sch    = col_ch[col_up];
  assign up_v   = (r_q == CW'(1)) ? '0 : rd_a[col_up];
  assign left_v = (c_q == CW'(1)) ? '0 : rd_b[col_left];

  // trace-back step selection
  always_comb begin
    push      = 1'b0;
    push_data = fch;
    unique case (state_q)
      ST_TB: begin
        if (r_q != '0 && c_q != '0) begin
          push = (fch == sch);
        end else if (r_q != '0) begin
          push = 1'b1;
        end else if (c_q != '0) begin
          push      = 1'b1;
          push_data = sch;
        end
      end
      ST_CMP: begin
        push      = 1'b1;
        push_data = (up_v > left_v) ? fch : sch;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // first string storage
  always_ff @(posedge clk_i) begin
    if (accept && (func == scs_pkg::FuncAppendFirst) && (f_cnt_q < CW'(MAX_LEN))) begin
      f_chars[f_cnt_q[IW-1:0]] <= sym;
    end
  end

  // reverse buffer, registered read
  always_ff @(posedge clk_i) begin
    if (push) begin
      rb_mem[len_q[RW-1:0]] <= push_data;
    end
    rb_rd_q <= rb_mem[RW'(ptr_q - LW'(1))];
  end

  // control and output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      f_cnt_q   <= '0;
      s_cnt_q   <= '0;
      ovf_q     <= 1'b0;
      trunc_q   <= 1'b0;
      fc_q      <= '0;
      r_q       <= '0;
      c_q       <= '0;
      len_q     <= '0;
      ptr_q     <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
      m_trunc_q <= 1'b0;
      m_sym_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (func == scs_pkg::FuncAppendFirst) begin
              if (f_cnt_q < CW'(MAX_LEN)) f_cnt_q <= f_cnt_q + CW'(1);
              else                         ovf_q   <= 1'b1;
            end else if (func == scs_pkg::FuncAppendSecond) begin
              if (s_cnt_q < CW'(MAX_LEN)) s_cnt_q <= s_cnt_q + CW'(1);
              else                         ovf_q   <= 1'b1;
            end else if (func == scs_pkg::FuncRun) begin
              trunc_q <= ovf_q;
              fc_q    <= '0;
              len_q   <= '0;
              r_q     <= f_cnt_q;
              c_q     <= s_cnt_q;
              state_q <= ST_FILL;
            end
          end
        end
        ST_FILL: begin
          fc_q <= fc_q + LW'(1);
          if (fc_q == LW'(f_cnt_q) + LW'(MAX_LEN)) state_q <= ST_TB;
        end
        ST_TB: begin
          if (r_q != '0 && c_q != '0) begin
            if (push) begin
              r_q <= r_q - CW'(1);
              c_q <= c_q - CW'(1);
            end else begin
              state_q <= ST_CMP;
            end
          end else if (r_q != '0) begin
            r_q <= r_q - CW'(1);
          end else if (c_q != '0) begin
            c_q <= c_q - CW'(1);
          end else begin
            f_cnt_q <= '0;
            s_cnt_q <= '0;
            ovf_q   <= 1'b0;
            ptr_q   <= len_q;
            state_q <= (len_q == '0) ? ST_IDLE : ST_RD;
          end
          if (push) len_q <= len_q + LW'(1);
        end
        ST_CMP: begin
          if (up_v > left_v) r_q <= r_q - CW'(1);
          else               c_q <= c_q - CW'(1);
          len_q   <= len_q + LW'(1);
          state_q <= ST_TB;
        end
        ST_RD: begin
          state_q <= ST_LD;
        end
        ST_LD: begin
          m_valid_q <= 1'b1;
          m_sym_q   <= rb_rd_q;
          m_last_q  <= (ptr_q == LW'(1));
          m_trunc_q <= trunc_q;
          ptr_q     <= ptr_q - LW'(1);
          state_q   <= ST_WAIT;
        end
        ST_WAIT: begin
          if (m_axis_tready) begin
            m_valid_q <= 1'b0;
            state_q   <= (ptr_q == '0) ? ST_IDLE : ST_RD;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_sym_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_trunc_q;

  // checks
  `SCS_ASSERT(a_no_accept_while_emitting, !(m_axis_tvalid && s_axis_tready),
    "input taken while an output beat is pending")
  `SCS_ASSERT_NEXT(a_idle_after_last, m_axis_tvalid && m_axis_tready && m_axis_tlast,
    state_q == ST_IDLE && f_cnt_q == '0 && s_cnt_q == '0 && !ovf_q,
    "strings not cleared after the final beat")
  `SCS_ASSERT(a_fill_quiet, !(state_q == ST_FILL && m_axis_tvalid),
    "output beat during table fill")

endmodule
